[src/assert_macros.svh]
// Assertion macros used by the RTL top level.
// No dependencies; ASSERT_OFF removes every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Combinational check on every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed");
// Same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[src/savm_pkg.sv]
// Types, codes and helpers of the stack accumulator VM core.
// No dependencies; used by savm_muldiv and the top level.
package savm_pkg;

    localparam int DATA_WORDS_DEF = 4096;
    localparam int CODE_WORDS_DEF = 65536;
    localparam int WORD_W         = 64;

    // Opcodes
    localparam logic [5:0] OP_LLA  = 6'd0;
    localparam logic [5:0] OP_IMM  = 6'd1;
    localparam logic [5:0] OP_JMP  = 6'd2;
    localparam logic [5:0] OP_JSR  = 6'd3;
    localparam logic [5:0] OP_BZ   = 6'd4;
    localparam logic [5:0] OP_BNZ  = 6'd5;
    localparam logic [5:0] OP_ENT  = 6'd6;
    localparam logic [5:0] OP_ADJ  = 6'd7;
    localparam logic [5:0] OP_LEV  = 6'd8;
    localparam logic [5:0] OP_LI   = 6'd9;
    localparam logic [5:0] OP_LC   = 6'd10;
    localparam logic [5:0] OP_SI   = 6'd11;
    localparam logic [5:0] OP_SC   = 6'd12;
    localparam logic [5:0] OP_PSH  = 6'd13;
    localparam logic [5:0] OP_OR   = 6'd14;
    localparam logic [5:0] OP_XOR  = 6'd15;
    localparam logic [5:0] OP_AND  = 6'd16;
    localparam logic [5:0] OP_EQ   = 6'd17;
    localparam logic [5:0] OP_NE   = 6'd18;
    localparam logic [5:0] OP_LT   = 6'd19;
    localparam logic [5:0] OP_GT   = 6'd20;
    localparam logic [5:0] OP_LE   = 6'd21;
    localparam logic [5:0] OP_GE   = 6'd22;
    localparam logic [5:0] OP_SHL  = 6'd23;
    localparam logic [5:0] OP_SHR  = 6'd24;
    localparam logic [5:0] OP_ADD  = 6'd25;
    localparam logic [5:0] OP_SUB  = 6'd26;
    localparam logic [5:0] OP_MUL  = 6'd27;
    localparam logic [5:0] OP_DIV  = 6'd28;
    localparam logic [5:0] OP_MOD  = 6'd29;
    localparam logic [5:0] OP_SYS0 = 6'd30;
    localparam logic [5:0] OP_SYS7 = 6'd37;
    localparam logic [5:0] OP_EXIT = 6'd38;

    // Item operations
    localparam logic OPER_EXEC    = 1'b0;
    localparam logic OPER_PRELOAD = 1'b1;

    // Status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EXITED   = 3'd1;
    localparam logic [2:0] ST_SYSCALL  = 3'd2;
    localparam logic [2:0] ST_BAD_OP   = 3'd3;
    localparam logic [2:0] ST_DIV_ZERO = 3'd4;
    localparam logic [2:0] ST_BAD_ADDR = 3'd5;
    localparam logic [2:0] ST_HALTED   = 3'd6;

    // Configuration register indexes
    localparam logic CFG_ENTRY_PC  = 1'b0;
    localparam logic CFG_STACK_TOP = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [5:0]        opcode;
        logic signed [63:0] operand;
        logic [11:0]       mem_address;
    } cmd_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [15:0]       next_pc;
        logic signed [63:0] acc;
        logic [15:0]       stack_ptr;
        logic signed [63:0] exit_code;
    } rsp_t;

    typedef enum logic [1:0] {
        MD_MUL = 2'd0,
        MD_DIV = 2'd1,
        MD_MOD = 2'd2
    } md_op_t;

    typedef struct packed {
        logic   start;
        md_op_t op;
    } md_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } md_rsp_t;

    function automatic logic [63:0] sext8(input logic [7:0] v);
        return {{56{v[7]}}, v};
    endfunction

endpackage

[src/stack_accumulator_vm_core_top.sv]
// Top level of the stack accumulator VM core: sequencer, word memory, state.
// Depends on savm_pkg, savm_muldiv and assert_macros.svh.
//
//  channel | direction | handshake            | payload
//  cmd     | in        | cmd_valid/cmd_ready  | cmd (cmd_t)
//  rsp     | out       | rsp_valid/rsp_ready  | rsp (rsp_t)
//  cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One beat at a time. LEV and SC take two reads on the single read port; MUL, DIV
// and MOD run 64 one-bit steps in the shared unit between start and done.
// After reset the word memory is cleared at one word per cycle with cmd_ready low;
// cfg writes are taken during the clear and while idle.
// A result waiting on rsp_ready does not stop the next cmd beat from entering;
// that beat then holds in the done state until the waiting result leaves.
`include "assert_macros.svh"
module stack_accumulator_vm_core_top #(
    parameter int DATA_WORDS = savm_pkg::DATA_WORDS_DEF,
    parameter int CODE_WORDS = savm_pkg::CODE_WORDS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  savm_pkg::cmd_t cmd,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output savm_pkg::rsp_t rsp,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic           cfg_index,
    input  logic [15:0]    cfg_data
);
    import savm_pkg::*;

    localparam int          AW       = $clog2(DATA_WORDS);
    localparam logic [63:0] MemBytes = 64'(DATA_WORDS) * 64'd8;
    localparam logic [63:0] PtrLimit = (MemBytes < 64'd65535) ? MemBytes : 64'd65535;
    localparam logic [15:0] CodeMask = (CODE_WORDS >= 65536) ? 16'hFFFF :
                                       16'(CODE_WORDS - 1);

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_DECODE = 7'b0000100,
        S_RD1    = 7'b0001000,
        S_RD2    = 7'b0010000,
        S_ARITH  = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t         state_reg, state_next;
    logic [63:0]    acc_reg, acc_next;
    logic [15:0]    pc_reg, pc_next;
    logic [15:0]    bp_reg, bp_next;
    logic [15:0]    sp_reg, sp_next;
    logic           halt_reg, halt_next;
    logic [2:0]     st_reg, st_next;
    logic [63:0]    exit_reg, exit_next;
    logic [63:0]    w1_reg, w1_next;
    logic [AW-1:0]  clr_reg, clr_next;
    cmd_t           item_reg;
    rsp_t           rsp_reg;
    logic           rsp_valid_reg;

    logic [63:0]    mem [DATA_WORDS];
    logic [63:0]    mem_rdata_reg;
    logic           mem_we;
    logic [AW-1:0]  mem_waddr, mem_raddr;
    logic [63:0]    mem_wdata;

    md_req_t        md_req;
    md_rsp_t        md_rsp;

    logic [63:0]    s64, b64, o8, v, rd, bsh;
    logic [15:0]    npc1, npc2;
    logic [5:0]     sh;

    function automatic logic word_ok(input logic [63:0] a);
        return (a[2:0] == 3'd0) && (a < MemBytes);
    endfunction

    function automatic logic pop_ok(input logic [63:0] s);
        return word_ok(s) && ((s + 64'd8) <= PtrLimit);
    endfunction

    function automatic logic push_ok(input logic [63:0] s);
        return (s >= 64'd8) && word_ok(s - 64'd8);
    endfunction

    function automatic logic [15:0] wrap(input logic [63:0] x);
        return x[15:0] & CodeMask;
    endfunction

    function automatic logic [AW-1:0] widx(input logic [63:0] a);
        return a[AW+2:3];
    endfunction

    assign cmd_ready = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) || (state_reg == S_CLEAR);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    savm_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .opa   (mem_rdata_reg),
        .opb   (acc_reg),
        .rsp   (md_rsp)
    );

    // Sequencer and next-state logic
    always_comb
    begin
        s64  = {48'd0, sp_reg};
        b64  = {48'd0, bp_reg};
        o8   = {item_reg.operand[60:0], 3'b000};
        npc1 = wrap(64'(pc_reg) + 64'd1);
        npc2 = wrap(64'(pc_reg) + 64'd2);
        v    = '0;
        rd   = mem_rdata_reg;
        bsh  = '0;
        sh   = '0;

        state_next = state_reg;
        acc_next   = acc_reg;
        pc_next    = pc_reg;
        bp_next    = bp_reg;
        sp_next    = sp_reg;
        halt_next  = halt_reg;
        st_next    = st_reg;
        exit_next  = exit_reg;
        w1_next    = w1_reg;
        clr_next   = clr_reg;
        mem_we     = 1'b0;
        mem_waddr  = widx(s64 - 64'd8);
        mem_wdata  = acc_reg;
        mem_raddr  = widx(s64);
        md_req     = '{start: 1'b0, op: MD_MUL};

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == AW'(DATA_WORDS - 1))
                    state_next = S_IDLE;
            end

            S_IDLE:
            begin
                if (cmd_valid)
                    state_next = S_DECODE;
            end

            S_DECODE:
            begin
                st_next    = ST_OK;
                exit_next  = '0;
                state_next = S_DONE;
                if (item_reg.operation == OPER_PRELOAD)
                begin
                    v = {52'd0, item_reg.mem_address};
                    if (v < 64'(DATA_WORDS))
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = v[AW-1:0];
                        mem_wdata = item_reg.operand;
                    end
                    else
                        st_next = ST_BAD_ADDR;
                end
                else if (halt_reg)
                    st_next = ST_HALTED;
                else
                begin
                    case (item_reg.opcode) inside
                        OP_LLA:
                        begin
                            acc_next = b64 + o8;
                            pc_next  = npc2;
                        end
                        OP_IMM:
                        begin
                            acc_next = item_reg.operand;
                            pc_next  = npc2;
                        end
                        OP_JMP:
                            pc_next = wrap(item_reg.operand);
                        OP_JSR:
                        begin
                            if (!push_ok(s64))
                                st_next = ST_BAD_ADDR;
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_wdata = {48'd0, npc2};
                                sp_next   = sp_reg - 16'd8;
                                pc_next   = wrap(item_reg.operand);
                            end
                        end
                        OP_BZ:
                            pc_next = (acc_reg == 64'd0) ? wrap(item_reg.operand) : npc2;
                        OP_BNZ:
                            pc_next = (acc_reg != 64'd0) ? wrap(item_reg.operand) : npc2;
                        OP_ENT:
                        begin
                            v = s64 - 64'd8 - o8;
                            if (!push_ok(s64) || (v > PtrLimit))
                                st_next = ST_BAD_ADDR;
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_wdata = b64;
                                bp_next   = sp_reg - 16'd8;
                                sp_next   = v[15:0];
                                pc_next   = npc2;
                            end
                        end
                        OP_ADJ:
                        begin
                            v = s64 + o8;
                            if (v > PtrLimit)
                                st_next = ST_BAD_ADDR;
                            else
                            begin
                                sp_next = v[15:0];
                                pc_next = npc2;
                            end
                        end
                        OP_LEV:
                        begin
                            if (!pop_ok(b64) || !pop_ok(b64 + 64'd8))
                                st_next = ST_BAD_ADDR;
                            else
                            begin
                                mem_raddr  = widx(b64);
                                state_next = S_RD1;
                            end
                        end
                        OP_LI:
                        begin
                            if (!word_ok(acc_reg))
                                st_next = ST_BAD_ADDR;
                            else
                            begin
                                mem_raddr  = widx(acc_reg);
                                state_next = S_RD1;
                            end
                        end
                        OP_LC:
                        begin
                            if (acc_reg >= MemBytes)
                                st_next = ST_BAD_ADDR;
                            else
                            begin
                                mem_raddr  = widx(acc_reg);
                                state_next = S_RD1;
                            end
                        end
                        OP_PSH:
                        begin
                            if (!push_ok(s64))
                                st_next = ST_BAD_ADDR;
                            else
                            begin
                                mem_we  = 1'b1;
                                sp_next = sp_reg - 16'd8;
                                pc_next = npc1;
                            end
                        end
                        OP_SI, OP_SC, [OP_OR:OP_MOD]:
                        begin
                            if (!pop_ok(s64))
                                st_next = ST_BAD_ADDR;
                            else
                                state_next = S_RD1;
                        end
                        [OP_SYS0:OP_SYS7]:
                        begin
                            st_next = ST_SYSCALL;
                            pc_next = npc1;
                        end
                        OP_EXIT:
                        begin
                            if (!word_ok(s64))
                                st_next = ST_BAD_ADDR;
                            else
                                state_next = S_RD1;
                        end
                        default:
                            st_next = ST_BAD_OP;
                    endcase
                end
            end

            S_RD1:
            begin
                state_next = S_DONE;
                case (item_reg.opcode) inside
                    OP_LEV:
                    begin
                        w1_next    = rd;
                        mem_raddr  = widx(b64 + 64'd8);
                        state_next = S_RD2;
                    end
                    OP_LI:
                    begin
                        acc_next = rd;
                        pc_next  = npc1;
                    end
                    OP_LC:
                    begin
                        sh       = {acc_reg[2:0], 3'b000};
                        bsh      = rd >> sh;
                        acc_next = sext8(bsh[7:0]);
                        pc_next  = npc1;
                    end
                    OP_SI:
                    begin
                        if (!word_ok(rd))
                            st_next = ST_BAD_ADDR;
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = widx(rd);
                            mem_wdata = acc_reg;
                            sp_next   = sp_reg + 16'd8;
                            pc_next   = npc1;
                        end
                    end
                    OP_SC:
                    begin
                        if (rd >= MemBytes)
                            st_next = ST_BAD_ADDR;
                        else
                        begin
                            w1_next    = rd;
                            mem_raddr  = widx(rd);
                            state_next = S_RD2;
                        end
                    end
                    OP_EXIT:
                    begin
                        exit_next = rd;
                        st_next   = ST_EXITED;
                        halt_next = 1'b1;
                        pc_next   = npc1;
                    end
                    OP_MUL, OP_DIV, OP_MOD:
                    begin
                        if ((item_reg.opcode != OP_MUL) && (acc_reg == 64'd0))
                            st_next = ST_DIV_ZERO;
                        else
                        begin
                            md_req.start = 1'b1;
                            md_req.op    = (item_reg.opcode == OP_MUL) ? MD_MUL :
                                           (item_reg.opcode == OP_DIV) ? MD_DIV : MD_MOD;
                            state_next   = S_ARITH;
                        end
                    end
                    default:
                    begin
                        // Binary operations: acc = b op acc
                        sp_next = sp_reg + 16'd8;
                        pc_next = npc1;
                        case (item_reg.opcode)
                            OP_OR:   acc_next = rd | acc_reg;
                            OP_XOR:  acc_next = rd ^ acc_reg;
                            OP_AND:  acc_next = rd & acc_reg;
                            OP_EQ:   acc_next = {63'd0, rd == acc_reg};
                            OP_NE:   acc_next = {63'd0, rd != acc_reg};
                            OP_LT:   acc_next = {63'd0, $signed(rd) < $signed(acc_reg)};
                            OP_GT:   acc_next = {63'd0, $signed(acc_reg) < $signed(rd)};
                            OP_LE:   acc_next = {63'd0, !($signed(acc_reg) < $signed(rd))};
                            OP_GE:   acc_next = {63'd0, !($signed(rd) < $signed(acc_reg))};
                            OP_SHL:  acc_next = rd << acc_reg[5:0];
                            OP_SHR:  acc_next = $unsigned($signed(rd) >>> acc_reg[5:0]);
                            OP_ADD:  acc_next = rd + acc_reg;
                            default: acc_next = rd - acc_reg;
                        endcase
                    end
                endcase
            end

            S_RD2:
            begin
                state_next = S_DONE;
                if (item_reg.opcode == OP_LEV)
                begin
                    if (w1_reg > PtrLimit)
                        st_next = ST_BAD_ADDR;
                    else
                    begin
                        bp_next = w1_reg[15:0];
                        pc_next = wrap(rd);
                        sp_next = bp_reg + 16'd16;
                    end
                end
                else
                begin
                    // Byte store: merge low accumulator byte into the word
                    sh        = {w1_reg[2:0], 3'b000};
                    mem_we    = 1'b1;
                    mem_waddr = widx(w1_reg);
                    mem_wdata = (rd & ~(64'hFF << sh)) | ({56'd0, acc_reg[7:0]} << sh);
                    acc_next  = sext8(acc_reg[7:0]);
                    sp_next   = sp_reg + 16'd8;
                    pc_next   = npc1;
                end
            end

            S_ARITH:
            begin
                if (md_rsp.done)
                begin
                    acc_next   = md_rsp.result;
                    sp_next    = sp_reg + 16'd8;
                    pc_next    = npc1;
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                    state_next = S_IDLE;
            end

            default:
                state_next = S_IDLE;
        endcase

        // Configuration writes land only while idle or clearing
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ENTRY_PC:
                    pc_next = cfg_data;
                CFG_STACK_TOP:
                begin
                    bp_next = cfg_data;
                    sp_next = cfg_data;
                end
                default:
                    pc_next = pc_reg;
            endcase
        end
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            acc_reg       <= '0;
            pc_reg        <= '0;
            bp_reg        <= 16'd32768;
            sp_reg        <= 16'd32768;
            halt_reg      <= 1'b0;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            pc_reg    <= pc_next;
            bp_reg    <= bp_next;
            sp_reg    <= sp_next;
            halt_reg  <= halt_next;
            clr_reg   <= clr_next;
            if ((state_reg == S_DONE) && (state_next == S_IDLE))
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        st_reg   <= st_next;
        exit_reg <= exit_next;
        w1_reg   <= w1_next;
        if (cmd_valid && cmd_ready)
            item_reg <= cmd;
        if ((state_reg == S_DONE) && (state_next == S_IDLE))
        begin
            rsp_reg.status    <= st_reg;
            rsp_reg.next_pc   <= pc_reg;
            rsp_reg.acc       <= acc_reg;
            rsp_reg.stack_ptr <= sp_reg;
            rsp_reg.exit_code <= exit_reg;
        end
    end

    // Word memory, one write port and one read port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        mem_rdata_reg <= mem[mem_raddr];
    end

    `ASSERT_ALWAYS(a_state_onehot, clk, rst_n, $onehot(state_reg))
    `ASSERT_IMPLIES(a_md_done_in_arith, clk, rst_n, md_rsp.done, state_reg == S_ARITH)
    `ASSERT_NEXT(a_accept_decodes, clk, rst_n, cmd_valid && cmd_ready, state_reg == S_DECODE)
    `ASSERT_NEXT(a_halted_status, clk, rst_n, (state_reg == S_DECODE) && halt_reg && (item_reg.operation == OPER_EXEC), st_reg == ST_HALTED)

endmodule

[src/savm_muldiv.sv]
// Shared iterative multiply / divide / modulo unit, one bit per cycle.
// Depends on savm_pkg.
module savm_muldiv (
    input  logic              clk,
    input  logic              rst_n,
    input  savm_pkg::md_req_t req,
    input  logic [63:0]       opa,   // left operand (popped word)
    input  logic [63:0]       opb,   // right operand (accumulator)
    output savm_pkg::md_rsp_t rsp
);
    import savm_pkg::*;

    localparam int CntW = $clog2(WORD_W);

    logic            busy_reg;
    logic            done_reg;
    logic [CntW-1:0] cnt_reg;
    md_op_t          op_reg;
    logic [63:0]     p_reg, x_reg, y_reg;
    logic [63:0]     rem_reg, q_reg, d_reg;
    logic            qneg_reg, rneg_reg;
    logic [64:0]     rs;
    logic [64:0]     diff;

    // Restoring divide step
    always_comb
    begin
        rs   = {rem_reg, q_reg[63]};
        diff = rs - {1'b0, d_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CntW'(WORD_W - 1));
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CntW'(WORD_W - 1))
                    busy_reg <= 1'b0;
            end
        end
    end

    // Datapath, no reset needed
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            op_reg   <= req.op;
            p_reg    <= '0;
            x_reg    <= opa;
            y_reg    <= opb;
            rem_reg  <= '0;
            q_reg    <= opa[63] ? (64'd0 - opa) : opa;
            d_reg    <= opb[63] ? (64'd0 - opb) : opb;
            qneg_reg <= opa[63] ^ opb[63];
            rneg_reg <= opa[63];
        end
        else if (busy_reg)
        begin
            if (op_reg == MD_MUL)
            begin
                if (y_reg[0])
                    p_reg <= p_reg + x_reg;
                x_reg <= {x_reg[62:0], 1'b0};
                y_reg <= {1'b0, y_reg[63:1]};
            end
            else if (!diff[64])
            begin
                rem_reg <= diff[63:0];
                q_reg   <= {q_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= rs[63:0];
                q_reg   <= {q_reg[62:0], 1'b0};
            end
        end
    end

    // Sign correction on the way out
    always_comb
    begin
        rsp.done = done_reg;
        case (op_reg)
            MD_MUL:  rsp.result = p_reg;
            MD_DIV:  rsp.result = qneg_reg ? (64'd0 - q_reg) : q_reg;
            default: rsp.result = rneg_reg ? (64'd0 - rem_reg) : rem_reg;
        endcase
    end

endmodule
